### sv/tgarle_pkg.sv
// Shared types and constants of the TGA RLE pixel encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tgarle_pkg;

   localparam int unsigned MAX_PACKET_DEF = 128;
   localparam int unsigned LANES          = 4;
   localparam int unsigned LANE_W         = 2;
   localparam int unsigned PIX_W          = 32;

   localparam logic [7:0] HDR_RAW    = 8'h00;
   localparam logic       REPEAT_BIT = 1'b1;

   typedef logic [PIX_W-1:0]            pixel_type;
   typedef logic [LANES-1:0][PIX_W-1:0] row_type;

   typedef enum logic [0:0] {
      CSR_COMPRESS_ENABLE = 1'b0,
      CSR_ALPHA_ENABLE    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       final_pixel;
   } req_type;

   typedef struct packed {
      logic       header_present;
      logic [7:0] header_byte;
      logic [2:0] pixel_count;
      pixel_type  pixel_word0;
      pixel_type  pixel_word1;
      pixel_type  pixel_word2;
      pixel_type  pixel_word3;
      logic       image_end;
   } rsp_type;

endpackage

### sv/tga_rle_pixel_encoder_top.sv
// Top level of the TGA RLE pixel encoder: packet sequencer, registers,
// output register. Uses tgarle_pkg and tgarle_raw_buf.
`timescale 1ns / 1ps

// TGA run-length encoder. Pixels come in on req_* in scan order; packets go
// out on rsp_* as items of up to four pixels. A repeat packet is one item
// (header 0x80 | count-1, one pixel). A raw packet starts with an item that
// carries its header (count-1) and continues with items of four pixels until
// the last, possibly shorter one. Packets hold at most MAX_PACKET pixels and run across
// rows; final_pixel closes the pending packet and marks the last item with
// image_end. With compress_enable low every pixel goes out as one item without
// header and the encoder state is left alone.
// Sequencing: a pixel that completes no packet, and a pass-through pixel,
// is taken in S_IDLE without leaving it, so such pixels stream at one per
// cycle. A pixel that breaks a run is accepted, then the packet it closes
// goes out, then S_START restarts the run with it. A repeat packet is one
// item, sent from S_REP. Each raw item reads one four-pixel row of the raw
// buffer (one read port, registered data) in S_RAW_RD before S_RAW_OUT
// presents it. A final pixel adds its closing packet: S_FINAL sends a
// repeat or one-pixel packet itself and hands a raw one on to the reads.
// The input stalls while an item waits in the output register for
// rsp_ready, and while the sequencer closes a packet or restarts a run.
// The raw buffer needs no clearing pass after reset: only entries already
// written are ever read.
// csr_ready is always high; write registers only while the block is idle.

module tga_rle_pixel_encoder_top #(
   parameter int unsigned MAX_PACKET = tgarle_pkg::MAX_PACKET_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // pixel items
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tgarle_pkg::req_type        req_data,
   // packet items
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tgarle_pkg::rsp_type        rsp_data,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  tgarle_pkg::csr_index_type  csr_index,
   input  logic                       csr_wdata
);
   import tgarle_pkg::*;

   // buffer geometry
   localparam int unsigned CNT_W = $clog2(MAX_PACKET + 1);   // holds 0..MAX_PACKET
   localparam int unsigned ENT_W = $clog2(MAX_PACKET);       // entry index
   localparam int unsigned ROWS  = (MAX_PACKET + LANES - 1) / LANES;
   localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int unsigned REM_W = CNT_W + 3;

   typedef enum logic [1:0] {
      MODE_EMPTY = 2'd0,   // nothing held
      MODE_ONE   = 2'd1,   // one pixel held
      MODE_REP   = 2'd2,   // repeat run
      MODE_RAW   = 2'd3    // raw run
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,      // take pixels
      S_REP,       // close a repeat run broken by the held pixel
      S_RAW_RD,    // read next row of the raw buffer
      S_RAW_OUT,   // present one raw item
      S_START,     // held pixel opens a new run
      S_FINAL      // close whatever is pending at image end
   } state_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   pixel_type         prev_ff, prev_in;
   logic [CNT_W-1:0]  rep_cnt_ff, rep_cnt_in;
   logic [CNT_W-1:0]  raw_cnt_ff, raw_cnt_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   pixel_type         pend_px_ff, pend_px_in;
   logic              pend_last_ff, pend_last_in;
   logic              final_ff, final_in;
   logic              compress_ff, compress_in;
   logic              alpha_ff, alpha_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // combinational helpers
   pixel_type         px;
   logic              out_free;
   logic              req_acc;
   logic              load_item;
   rsp_type           item;
   logic              wr_en;
   logic [ENT_W-1:0]  wr_idx;
   logic [ENT_W+1:0]  wr_idx_ext;
   pixel_type         wr_px;
   logic              rd_en;
   row_type           rd_row_data;
   logic [CNT_W-1:0]  rep_m1;
   logic [CNT_W-1:0]  raw_m1;
   logic [CNT_W-1:0]  rem;
   logic [REM_W-1:0]  rem_ext;
   logic [2:0]        n_pix;
   logic [CNT_W-1:0]  pos_next;
   logic [7:0]        hdr_rep;
   logic [7:0]        hdr_raw;

   // incoming pixel, packed b | g<<8 | r<<16 | a<<24
   assign px = {(alpha_ff ? req_data.alpha : 8'h00),
                req_data.red, req_data.green, req_data.blue};

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rep_m1  = rep_cnt_ff - CNT_W'(1);
   assign raw_m1  = raw_cnt_ff - CNT_W'(1);
   assign hdr_rep = {REPEAT_BIT, 7'(rep_m1)};
   assign hdr_raw = HDR_RAW | {1'b0, 7'(raw_m1)};

   // raw drain: pixels left and size of this item
   assign rem      = raw_cnt_ff - pos_ff;
   assign rem_ext  = REM_W'(rem);
   assign n_pix    = (rem_ext > REM_W'(LANES)) ? 3'(LANES) : 3'(rem);
   assign pos_next = pos_ff + CNT_W'(n_pix);

   assign wr_idx_ext = {2'b00, wr_idx};

   tgarle_raw_buf #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
   ) u_raw_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_row  (ROW_W'(wr_idx_ext >> LANE_W)),
      .wr_lane (wr_idx_ext[LANE_W-1:0]),
      .wr_data (wr_px),
      .rd_en   (rd_en),
      .rd_row  (ROW_W'(pos_ff >> LANE_W)),
      .rd_data (rd_row_data)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      prev_in      = prev_ff;
      rep_cnt_in   = rep_cnt_ff;
      raw_cnt_in   = raw_cnt_ff;
      pos_in       = pos_ff;
      pend_px_in   = pend_px_ff;
      pend_last_in = pend_last_ff;
      final_in     = final_ff;
      wr_en        = 1'b0;
      wr_idx       = ENT_W'(raw_cnt_ff);
      wr_px        = px;
      rd_en        = 1'b0;
      load_item    = 1'b0;
      item         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (!compress_ff) begin
                  load_item          = 1'b1;
                  item.pixel_count   = 3'd1;
                  item.pixel_word0   = px;
                  item.image_end     = req_data.final_pixel;
               end else begin
                  pend_px_in   = px;
                  pend_last_in = req_data.final_pixel;
                  if (req_data.final_pixel) begin
                     state_in = S_FINAL;
                  end
                  case (mode_ff)
                     MODE_EMPTY: begin
                        wr_en      = 1'b1;
                        wr_idx     = '0;
                        prev_in    = px;
                        mode_in    = MODE_ONE;
                        raw_cnt_in = CNT_W'(1);
                        rep_cnt_in = '0;
                     end
                     MODE_ONE: begin
                        if (px == prev_ff) begin
                           mode_in    = MODE_REP;
                           rep_cnt_in = CNT_W'(2);
                        end else begin
                           wr_en      = 1'b1;
                           wr_idx     = ENT_W'(1);
                           prev_in    = px;
                           mode_in    = MODE_RAW;
                           raw_cnt_in = CNT_W'(2);
                        end
                     end
                     MODE_REP: begin
                        if (px == prev_ff && rep_cnt_ff < CNT_W'(MAX_PACKET)) begin
                           rep_cnt_in = rep_cnt_ff + CNT_W'(1);
                        end else begin
                           state_in = S_REP;
                        end
                     end
                     default: begin
                        if (px != prev_ff && raw_cnt_ff < CNT_W'(MAX_PACKET)) begin
                           wr_en      = 1'b1;
                           prev_in    = px;
                           raw_cnt_in = raw_cnt_ff + CNT_W'(1);
                        end else begin
                           pos_in   = '0;
                           final_in = 1'b0;
                           state_in = S_RAW_RD;
                        end
                     end
                  endcase
               end
            end
         end

         S_REP: begin
            if (out_free) begin
               load_item           = 1'b1;
               item.header_present = 1'b1;
               item.header_byte    = hdr_rep;
               item.pixel_count    = 3'd1;
               item.pixel_word0    = prev_ff;
               state_in            = S_START;
            end
         end

         S_START: begin
            wr_en      = 1'b1;
            wr_idx     = '0;
            wr_px      = pend_px_ff;
            prev_in    = pend_px_ff;
            mode_in    = MODE_ONE;
            raw_cnt_in = CNT_W'(1);
            rep_cnt_in = '0;
            state_in   = pend_last_ff ? S_FINAL : S_IDLE;
         end

         S_FINAL: begin
            case (mode_ff)
               MODE_REP: begin
                  if (out_free) begin
                     load_item           = 1'b1;
                     item.header_present = 1'b1;
                     item.header_byte    = hdr_rep;
                     item.pixel_count    = 3'd1;
                     item.pixel_word0    = prev_ff;
                     item.image_end      = 1'b1;
                     mode_in             = MODE_EMPTY;
                     raw_cnt_in          = '0;
                     rep_cnt_in          = '0;
                     state_in            = S_IDLE;
                  end
               end
               MODE_ONE: begin
                  // single held pixel: raw packet of one, no buffer read
                  if (out_free) begin
                     load_item           = 1'b1;
                     item.header_present = 1'b1;
                     item.header_byte    = HDR_RAW;
                     item.pixel_count    = 3'd1;
                     item.pixel_word0    = prev_ff;
                     item.image_end      = 1'b1;
                     mode_in             = MODE_EMPTY;
                     raw_cnt_in          = '0;
                     rep_cnt_in          = '0;
                     state_in            = S_IDLE;
                  end
               end
               MODE_RAW: begin
                  pos_in   = '0;
                  final_in = 1'b1;
                  state_in = S_RAW_RD;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_RAW_RD: begin
            rd_en    = 1'b1;
            state_in = S_RAW_OUT;
         end

         S_RAW_OUT: begin
            if (out_free) begin
               load_item           = 1'b1;
               item.header_present = (pos_ff == '0);
               item.header_byte    = (pos_ff == '0) ? hdr_raw : 8'h00;
               item.pixel_count    = n_pix;
               item.pixel_word0    = rd_row_data[0];
               item.pixel_word1    = (n_pix > 3'd1) ? rd_row_data[1] : '0;
               item.pixel_word2    = (n_pix > 3'd2) ? rd_row_data[2] : '0;
               item.pixel_word3    = (n_pix > 3'd3) ? rd_row_data[3] : '0;
               pos_in              = pos_next;
               if (pos_next >= raw_cnt_ff) begin
                  if (final_ff) begin
                     item.image_end = 1'b1;
                     mode_in        = MODE_EMPTY;
                     raw_cnt_in     = '0;
                     rep_cnt_in     = '0;
                     state_in       = S_IDLE;
                  end else begin
                     state_in = S_START;
                  end
               end else begin
                  state_in = S_RAW_RD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_item) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = item;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register writes
   always_comb begin
      compress_in = compress_ff;
      alpha_in    = alpha_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COMPRESS_ENABLE: compress_in = csr_wdata;
            CSR_ALPHA_ENABLE:    alpha_in    = csr_wdata;
            default: begin
               compress_in = compress_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_EMPTY;
         prev_ff      <= '0;
         rep_cnt_ff   <= '0;
         raw_cnt_ff   <= '0;
         pos_ff       <= '0;
         pend_last_ff <= 1'b0;
         final_ff     <= 1'b0;
         compress_ff  <= 1'b1;
         alpha_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         prev_ff      <= prev_in;
         rep_cnt_ff   <= rep_cnt_in;
         raw_cnt_ff   <= raw_cnt_in;
         pos_ff       <= pos_in;
         pend_last_ff <= pend_last_in;
         final_ff     <= final_in;
         compress_ff  <= compress_in;
         alpha_ff     <= alpha_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_px_ff  <= pend_px_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/tgarle_raw_buf.sv
// Raw pixel buffer: rows of four pixels, one lane written per cycle,
// one row read per cycle with registered data. Uses tgarle_pkg.
`timescale 1ns / 1ps

module tgarle_raw_buf #(
   parameter int unsigned ROWS  = 32,
   parameter int unsigned ROW_W = 5
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ROW_W-1:0]                wr_row,
   input  logic [tgarle_pkg::LANE_W-1:0]   wr_lane,
   input  tgarle_pkg::pixel_type           wr_data,
   input  logic                            rd_en,
   input  logic [ROW_W-1:0]                rd_row,
   output tgarle_pkg::row_type             rd_data
);
   import tgarle_pkg::*;

   row_type mem [ROWS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_lane] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/tgarle_checker.sv
// Port-level checks of the TGA RLE pixel encoder, bound to the top level.
// Uses tgarle_pkg; attaches to tga_rle_pixel_encoder_top.
`timescale 1ns / 1ps

module tgarle_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tgarle_pkg::rsp_type  rsp_data
);
   import tgarle_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pixel_count >= 3'd1 && rsp_data.pixel_count <= 3'd4)
      else $error("pixel count out of range");

   a_no_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.header_present |-> rsp_data.header_byte == 8'h00)
      else $error("header byte set on continuation item");

   a_repeat_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.header_present && rsp_data.header_byte[7]
      |-> rsp_data.pixel_count == 3'd1)
      else $error("repeat packet with more than one pixel");

   a_unused_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pixel_count != 3'd4 |-> rsp_data.pixel_word3 == '0)
      else $error("pixel word beyond count not zero");

endmodule

bind tga_rle_pixel_encoder_top tgarle_checker u_tgarle_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/sv/tb.sv
// Self-checking testbench for the TGA RLE pixel encoder: pixel driver, packet
// monitor and an in-line packet predictor. Depends on tgarle_pkg and
// tga_rle_pixel_encoder_top only.
`timescale 1ns / 1ps

module tb;
   import tgarle_pkg::*;

   localparam int PKT_MAX       = MAX_PACKET_DEF;
   localparam int SETTLE_CYCLES = 48;      // covers one pixel in flight plus a short flush
   localparam int HOLD_CYCLES   = 400;     // long rsp back-pressure stretch
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum logic [1:0] {MODE_EMPTY, MODE_ONE, MODE_RUN, MODE_RAW} enc_mode_type;
   typedef enum int {SEG_RUN, SEG_RAW, SEG_ALPHA_TWIN} seg_kind_type;

   // ---------------------------------------------------------------- DUT ports
   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_COMPRESS_ENABLE;
   logic          csr_wdata = 1'b0;

   // ------------------------------------------------------- bench bookkeeping
   req_type   pending_pixels[$];   // pixels waiting to be offered
   rsp_type   expected_packets[$]; // packet items the encoder still owes
   int        send_idle_pct  = 0;
   int        recv_stall_pct = 0;
   bit        hold_armed     = 1'b0;
   bit        hold_taken     = 1'b0;
   int        hold_left      = 0;
   int        cycle_count    = 0;
   int        fail_count     = 0;
   int        pixels_queued  = 0;
   int        pixels_accepted = 0;
   int        items_checked  = 0;
   int        phase_count    = 0;

   // Predictor state: register copies plus the encoder's run bookkeeping.
   logic         cfg_compress = 1'b1;
   logic         cfg_alpha    = 1'b0;
   enc_mode_type enc_mode     = MODE_EMPTY;
   pixel_type    held_px      = '0;
   int           run_len      = 0;
   pixel_type    raw_store[PKT_MAX];
   int           raw_len      = 0;

   tga_rle_pixel_encoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------ prediction
   // Repeat packet: one item, header carries the repeat flag and count-1.
   function automatic void emit_run();
      rsp_type    item;
      logic [7:0] len_m1;
      len_m1 = 8'(run_len - 1);
      item = '0;
      item.header_present = 1'b1;
      item.header_byte    = {REPEAT_BIT, len_m1[6:0]};
      item.pixel_count    = 3'd1;
      item.pixel_word0    = held_px;
      expected_packets = {expected_packets, item};
   endfunction

   // Raw packet: header on the first item, then four pixels per item,
   // the last item possibly short. Unused words read as zero.
   function automatic void emit_raw();
      rsp_type    item;
      pixel_type  w[4];
      logic [7:0] len_m1;
      int         pos;
      int         n;
      len_m1 = 8'(raw_len - 1);
      pos = 0;
      while (pos < raw_len) begin
         n = (raw_len - pos > LANES) ? LANES : raw_len - pos;
         for (int i = 0; i < 4; i++) w[i] = (i < n) ? raw_store[pos + i] : '0;
         item = '0;
         item.header_present = (pos == 0);
         item.header_byte    = (pos == 0) ? (HDR_RAW | {1'b0, len_m1[6:0]}) : 8'h00;
         item.pixel_count    = n[2:0];
         item.pixel_word0    = w[0];
         item.pixel_word1    = w[1];
         item.pixel_word2    = w[2];
         item.pixel_word3    = w[3];
         expected_packets = {expected_packets, item};
         pos += n;
      end
   endfunction

   function automatic void start_one(pixel_type px);
      held_px      = px;
      enc_mode     = MODE_ONE;
      raw_store[0] = px;
      raw_len      = 1;
      run_len      = 0;
   endfunction

   // Works out the packet items one accepted pixel causes.
   function automatic void encode_pixel(req_type px_in);
      pixel_type px;
      rsp_type   item;
      // alpha is dropped before any comparison when disabled
      px = {cfg_alpha ? px_in.alpha : 8'h00, px_in.red, px_in.green, px_in.blue};
      if (!cfg_compress) begin
         item = '0;
         item.pixel_count = 3'd1;
         item.pixel_word0 = px;
         item.image_end   = px_in.final_pixel;
         expected_packets = {expected_packets, item};
         return;
      end
      case (enc_mode)
         MODE_EMPTY: start_one(px);
         MODE_ONE: begin
            if (px == held_px) begin
               enc_mode = MODE_RUN;
               run_len  = 2;
            end else begin
               enc_mode     = MODE_RAW;
               held_px      = px;
               raw_store[1] = px;
               raw_len      = 2;
            end
         end
         MODE_RUN: begin
            if (px == held_px && run_len < PKT_MAX) begin
               run_len++;
            end else begin
               emit_run();
               start_one(px);
            end
         end
         default: begin
            if (px != held_px && raw_len < PKT_MAX) begin
               raw_store[raw_len] = px;
               raw_len++;
               held_px = px;
            end else begin
               // raw buffer full, or an equal pixel ends the literal stretch
               emit_raw();
               start_one(px);
            end
         end
      endcase
      if (px_in.final_pixel) begin
         // close whatever is pending; a lone held pixel goes out as raw of one
         if (enc_mode == MODE_RUN) emit_run();
         else emit_raw();
         item = expected_packets[expected_packets.size() - 1];
         item.image_end = 1'b1;
         expected_packets[expected_packets.size() - 1] = item;
         enc_mode = MODE_EMPTY;
         raw_len  = 0;
         run_len  = 0;
      end
   endfunction

   // ------------------------------------------------------------- driver side
   // Offers queued pixels; predicts at the edge where an item is accepted.
   always @(posedge clock) begin : pixel_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            encode_pixel(req_data);
            pixels_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_pixels.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off once armed so that the
   // output register fills and the encoder has to stall its pixel input.
   always @(posedge clock) begin : packet_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Every accepted packet item is matched against the oldest prediction.
   always @(posedge clock) begin : packet_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_packets.size() == 0) begin
            $error("packet item with nothing expected: 0x%0h", rsp_data);
            fail_count++;
         end else begin
            want = expected_packets.pop_front();
            check_field("header_present", 32'(want.header_present),
                        32'(rsp_data.header_present));
            check_field("header_byte", 32'(want.header_byte), 32'(rsp_data.header_byte));
            check_field("pixel_count", 32'(want.pixel_count), 32'(rsp_data.pixel_count));
            check_field("pixel_word0", want.pixel_word0, rsp_data.pixel_word0);
            check_field("pixel_word1", want.pixel_word1, rsp_data.pixel_word1);
            check_field("pixel_word2", want.pixel_word2, rsp_data.pixel_word2);
            check_field("pixel_word3", want.pixel_word3, rsp_data.pixel_word3);
            check_field("image_end", 32'(want.image_end), 32'(rsp_data.image_end));
         end
         items_checked++;
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // -------------------------------------------------------------- stimulus
   task automatic queue_pixel(req_type px);
      pending_pixels = {pending_pixels, px};
      pixels_queued++;
   endtask

   task automatic queue_rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] a, logic last);
      req_type px;
      px = '{red: r, green: g, blue: b, alpha: a, final_pixel: last};
      queue_pixel(px);
   endtask

   function automatic req_type random_pixel();
      req_type px;
      px.red         = 8'($urandom_range(255));
      px.green       = 8'($urandom_range(255));
      px.blue        = 8'($urandom_range(255));
      px.alpha       = 8'($urandom_range(255));
      px.final_pixel = 1'b0;
      return px;
   endfunction

   // One stretch of an image. Runs repeat one color (alpha varies when it is
   // ignored); raw stretches are fresh colors; an alpha twin repeats the last
   // queued color with alpha inverted, which only matters with alpha on.
   task automatic add_segment(seg_kind_type kind, int len);
      req_type px;
      px = random_pixel();
      case (kind)
         SEG_RUN: begin
            repeat (len) begin
               queue_pixel(px);
               if (!cfg_alpha) px.alpha = 8'($urandom_range(255));
            end
         end
         SEG_RAW: begin
            repeat (len) begin
               queue_pixel(px);
               px = random_pixel();
            end
         end
         default: begin
            if (pending_pixels.size() != 0) px = pending_pixels[pending_pixels.size() - 1];
            px.alpha       = ~px.alpha;
            px.final_pixel = 1'b0;
            repeat (len) queue_pixel(px);
         end
      endcase
   endtask

   // Marks the last queued pixel as the end of the image.
   task automatic close_image();
      req_type px;
      px = pending_pixels[pending_pixels.size() - 1];
      px.final_pixel = 1'b1;
      pending_pixels[pending_pixels.size() - 1] = px;
   endtask

   task automatic write_csr(csr_index_type idx, logic val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_COMPRESS_ENABLE) cfg_compress = val;
      else cfg_alpha = val;
   endtask

   // Registers are only touched here, with the encoder idle.
   task automatic start_phase(logic compress, logic alpha, int idle_pct, int stall_pct);
      write_csr(CSR_COMPRESS_ENABLE, compress);
      write_csr(CSR_ALPHA_ENABLE, alpha);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      phase_count++;
   endtask

   // Waits until every pixel is in and every predicted item is out, then lets
   // the encoder settle (a pixel that owes nothing may still be in work).
   task automatic drain();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_packets.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Whole images of random stretches until about n_pixels are queued.
   task automatic random_images(int n_pixels, int max_len);
      int target;
      target = pixels_queued + n_pixels;
      while (pixels_queued < target) begin
         repeat ($urandom_range(4, 1))
            add_segment(seg_kind_type'($urandom_range(2)), $urandom_range(max_len, 1));
         close_image();
      end
   endtask

   initial begin : sequencer
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed: compression on, alpha ignored
      start_phase(1'b1, 1'b0, 0, 0);
      queue_rgba(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);   // differs only in ignored alpha
      queue_rgba(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_rgba(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);   // final closes a run of three
      queue_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);   // single-pixel image
      queue_rgba(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
      queue_rgba(8'h00, 8'hFF, 8'h00, 8'h00, 1'b0);
      queue_rgba(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);
      queue_rgba(8'h00, 8'h00, 8'hFF, 8'h00, 1'b0);   // equal pixel ends the raw stretch
      queue_rgba(8'h12, 8'h34, 8'h56, 8'h78, 1'b1);
      for (int i = 1; i <= 6; i++)                    // raw of six: two items
         queue_rgba(8'(i), 8'(i * 17), 8'(255 - i), 8'h00, i == 6);
      queue_rgba(8'hAA, 8'hAA, 8'hAA, 8'h00, 1'b0);
      queue_rgba(8'hAA, 8'hAA, 8'hAA, 8'h00, 1'b0);
      queue_rgba(8'h55, 8'h55, 8'h55, 8'h00, 1'b1);   // run broken, then lone final
      drain();

      // --- directed: alpha kept, so alpha alone makes pixels differ
      start_phase(1'b1, 1'b1, 0, 0);
      queue_rgba(8'h10, 8'h20, 8'h30, 8'h40, 1'b0);
      queue_rgba(8'h10, 8'h20, 8'h30, 8'h41, 1'b1);
      drain();

      // --- directed: pass-through
      start_phase(1'b0, 1'b1, 0, 0);
      queue_rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      queue_rgba(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      drain();

      // --- random phases
      start_phase(1'b1, 1'b0, 0, 0);
      random_images(12, 6);
      drain();

      // sender idles; the phase ends with a raw stretch left open
      start_phase(1'b1, 1'b1, 76, 0);
      random_images(12, 6);
      add_segment(SEG_RAW, 3);
      drain();

      // pass-through must leave the open stretch alone
      start_phase(1'b0, 1'b1, 0, 76);
      random_images(8, 4);
      drain();

      start_phase(1'b1, 1'b0, 0, 76);
      random_images(12, 6);
      drain();

      start_phase(1'b1, 1'b1, 18, 18);
      random_images(14, 10);
      drain();

      // back-pressure: receiver holds off while short runs keep closing packets
      start_phase(1'b1, 1'b1, 0, 0);
      hold_armed = 1'b1;
      random_images(15, 6);
      drain();

      start_phase(1'b0, 1'b0, 18, 18);
      random_images(8, 4);
      drain();

      $display("Ran %0d configuration phases: %0d pixels in, %0d packet items checked.",
               phase_count, pixels_accepted, items_checked);
      $display("Covered runs, raw stretches, run breaks, alpha on/off, pass-through, stalls.");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
